FILE: rtl/sorted_unique_set_top_assert.svh
// Assertion macros for the sorted set block.
// Used by sorted_unique_set_top; needs a clock named clock and a reset named reset.
`ifndef SORTED_UNIQUE_SET_TOP_ASSERT_SVH
`define SORTED_UNIQUE_SET_TOP_ASSERT_SVH

// Same-cycle implication.
`define SUS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SUS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sus_pkg.sv
// Shared types and constants for the sorted set block.
// No dependencies.
package sus_pkg;

   localparam int VAL_W         = 32;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 3;
   localparam int POS_W         = 4;
   localparam int COUNT_OUT_W   = 5;
   localparam int CAPACITY_DEF  = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

   typedef struct packed {
      logic cmp;   // register the compare against the key
      logic ins;   // shift right from the insert point
      logic rem;   // shift left from the removed entry
   } cell_ctl_type;

endpackage

FILE: rtl/sorted_unique_set_top.sv
// Sorted set of distinct signed 32-bit values built as a chain of cells.
// Depends on sus_pkg, sus_cell and sorted_unique_set_top_assert.svh.
//
// Usage:
//   req channel (req_valid/req_stall) carries operation and value; an item
//   is taken at an edge with req_valid high and req_stall low.
//   rsp channel (rsp_valid/rsp_stall) returns status, position and
//   entry_count, one result item per request, in order.
// Sequence:
//   The key register takes the item, then every cell registers its compare
//   with the key in parallel, then the chain shifts and the result register
//   loads. req_stall stays high from the accepting edge until the shift step
//   is done, so a new item is not taken before the last one is through; the
//   single shared key register feeds all cells.
// Reset:
//   Synchronous; empties the set and drops any pending result. Entries are
//   not cleared, the count alone marks which cells hold values.
// Stall:
//   A waiting result sits in the output register; the next item is still
//   taken and compared, and its shift step holds until the result is taken.
module sorted_unique_set_top import sus_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_operation,
   input  logic signed [VAL_W-1:0]    req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [POS_W-1:0]           rsp_position,
   output logic [COUNT_OUT_W-1:0]     rsp_entry_count
);

`include "sorted_unique_set_top_assert.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [COUNT_OUT_W-1:0]  rcount_ff, rcount_in;

   logic signed [VAL_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]     lt_vec, eq_vec, valid_vec;
   logic [CAPACITY:0]       lt_ext;
   logic [CNT_W-1:0]        idx;
   logic                    found, ins_do, rem_do, advance, req_take;
   logic [POS_W+CNT_W-1:0]  pos_wide, cnt_wide;
   cell_ctl_type            ctl;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign advance = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // sorted index = one past the last cell below the key
   assign lt_ext = {1'b0, lt_vec};
   always_comb begin
      idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (lt_ext[i] && !lt_ext[i+1]) begin
            idx = idx | CNT_W'(i + 1);
         end
      end
   end

   assign found  = |eq_vec;
   assign ins_do = (op_ff == OP_INSERT) && !found && (count_ff < CNT_W'(CAPACITY));
   assign rem_do = (op_ff == OP_REMOVE) && (count_ff != '0) && found;

   always_comb begin
      ctl.cmp = (state_ff == S_CMP);
      ctl.ins = advance && ins_do;
      ctl.rem = advance && rem_do;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign valid_vec[g] = (CNT_W'(g) < count_ff);
         sus_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .valid       (valid_vec[g]),
            .key         (key_ff),
            .left_entry  ((g == 0) ? key_ff : entry_vec[(g == 0) ? 0 : g - 1]),
            .left_lt     ((g == 0) ? 1'b1 : lt_vec[(g == 0) ? 0 : g - 1]),
            .right_entry (entry_vec[(g == CAPACITY - 1) ? g : g + 1]),
            .entry       (entry_vec[g]),
            .lt          (lt_vec[g]),
            .eq          (eq_vec[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      pos_in       = pos_ff;
      rcount_in    = rcount_ff;
      pos_wide     = (POS_W + CNT_W)'(idx);
      cnt_wide     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               key_in   = req_value;
               op_in    = req_operation;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (advance) begin
               if (ins_do) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (rem_do) begin
                  count_in = count_ff - CNT_W'(1);
               end
               status_in = STATUS_OK;
               case (op_ff)
                  OP_INSERT: begin
                     if (found) begin
                        status_in = STATUS_DUP;
                     end else if (!ins_do) begin
                        status_in = STATUS_FULL;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else if (!found) begin
                        status_in = STATUS_MISSING;
                     end
                  end
                  default: begin
                     if (!found) begin
                        status_in = STATUS_MISSING;
                     end
                  end
               endcase
               // position reads zero on any error but a duplicate
               pos_in = ((status_in == STATUS_OK) || (status_in == STATUS_DUP)) ?
                        pos_wide[POS_W-1:0] : '0;
               cnt_wide     = (POS_W + CNT_W)'(count_in);
               rcount_in    = COUNT_OUT_W'(cnt_wide);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      op_ff     <= op_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      rcount_ff <= rcount_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_ff;
   assign rsp_entry_count = rcount_ff;

   `SUS_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `SUS_ASSERT_NOW(a_lt_thermo, state_ff == S_EXEC, ((lt_vec >> 1) & ~lt_vec) == '0, "lt not thermometer")
   `SUS_ASSERT_NOW(a_eq_single, state_ff == S_EXEC, $onehot0(eq_vec), "key matches twice")
   `SUS_ASSERT_NEXT(a_ins_count, advance && ins_do, count_ff == $past(count_ff) + CNT_W'(1), "insert count")
   `SUS_ASSERT_NOW(a_rsp_src, $rose(rsp_valid_ff), $past(state_ff) == S_EXEC, "result without shift step")

endmodule

FILE: rtl/sus_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the key
// and takes a neighbor's entry on insert or remove. Depends on sus_pkg.
module sus_cell import sus_pkg::*; (
   input  logic                    clock,
   input  cell_ctl_type            ctl,
   input  logic                    valid,
   input  logic signed [VAL_W-1:0] key,
   input  logic signed [VAL_W-1:0] left_entry,
   input  logic                    left_lt,
   input  logic signed [VAL_W-1:0] right_entry,
   output logic signed [VAL_W-1:0] entry,
   output logic                    lt,
   output logic                    eq
);

   logic signed [VAL_W-1:0] entry_ff, entry_in;
   logic                    lt_ff, lt_in;
   logic                    eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctl.cmp) begin
         lt_in = valid && (entry_ff < key);
         eq_in = valid && (entry_ff == key);
      end
      // entries below the key stay put
      if (ctl.ins && !lt_ff) begin
         entry_in = left_lt ? key : left_entry;
      end else if (ctl.rem && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule
